// ----- hdl/mtsp_pkg.sv -----
// package for the min timestamp slot pool: sizes, payload structs, status codes
// and the slot memory port structs; no dependencies
`default_nettype none

package mtsp_pkg;

  localparam int POOL_DEPTH = 16;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int ACT_W      = 5;
  localparam int LIVE_W     = 5;
  localparam int STAMP_W    = 64;
  localparam int HANDLE_W   = 32;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [ACT_W-1:0]    act_t;
  typedef logic [LIVE_W-1:0]   live_t;
  typedef logic [STAMP_W-1:0]  stamp_t;
  typedef logic [HANDLE_W-1:0] pld_handle_t;

  localparam act_t ACTIVE_RESET   = 5'd10;
  localparam act_t DEFAULT_ACTIVE = 5'd10;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_FULL     = 2'd1,
    ST_RETURNED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic        req_type;
    stamp_t      time_stamp;
    pld_handle_t payload_handle;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    stamp_t      out_stamp;
    pld_handle_t out_handle;
    live_t       live_entries;
  } out_item_t;

  typedef struct packed {
    stamp_t      stamp;
    pld_handle_t handle;
  } slot_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    slot_t data;
  } ram_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
  } ram_rd_t;

  // live count as reported: masked to the field width
  function automatic live_t live_of(input count_t c);
    return LIVE_W'(c);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mtsp_slot_ram.sv -----
// slot memory: timestamp and handle per slot, one write and one registered read
// per cycle; depends on mtsp_pkg
`default_nettype none

module mtsp_slot_ram (
  input  wire                clk,
  input  mtsp_pkg::ram_wr_t  wr,
  input  mtsp_pkg::ram_rd_t  rd,
  output mtsp_pkg::slot_t    rd_data
);
  import mtsp_pkg::*;

  slot_t mem [POOL_DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hdl/mtsp_seq.sv -----
// request sequencer: slot scan, valid bits, live count and the shared 64-bit
// timestamp compare; depends on mtsp_pkg, drives the slot memory ports
`default_nettype none

module mtsp_seq (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  mtsp_pkg::in_item_t   in_item,
  input  mtsp_pkg::idx_t       last_idx,
  output logic                 res_valid,
  input  wire                  res_ready,
  output mtsp_pkg::out_item_t  res_item,
  output mtsp_pkg::ram_wr_t    ram_wr,
  output mtsp_pkg::ram_rd_t    ram_rd,
  input  mtsp_pkg::slot_t      rd_data
);
  import mtsp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_GET,
    S_DRAIN,
    S_FIN,
    S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  idx_t                    idx_r, idx_nxt;
  logic [POOL_DEPTH-1:0]   valid_r, valid_nxt;
  count_t                  count_r, count_nxt;
  in_item_t                req_r, req_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    rd_hit_r, rd_hit_nxt;
  idx_t                    rd_idx_r, rd_idx_nxt;
  logic                    found_r, found_nxt;
  idx_t                    best_idx_r, best_idx_nxt;
  slot_t                   best_r, best_nxt;
  out_item_t               res_r, res_nxt;
  logic                    cmp_take;

  // shared compare; ties go to the later (higher) slot
  assign cmp_take = rd_pend_r && rd_hit_r && (!found_r || (rd_data.stamp <= best_r.stamp));

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    valid_nxt    = valid_r;
    count_nxt    = count_r;
    req_nxt      = req_r;
    rd_pend_nxt  = rd_pend_r;
    rd_hit_nxt   = rd_hit_r;
    rd_idx_nxt   = rd_idx_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    res_nxt      = res_r;
    ram_wr       = '0;
    ram_rd       = '0;

    if (cmp_take) begin
      found_nxt    = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_nxt     = rd_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_item;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          rd_pend_nxt = 1'b0;
          state_nxt   = (in_item.req_type == REQ_PUT) ? S_PUT : S_GET;
        end
      end
      S_PUT: begin
        if (!valid_r[idx_r]) begin
          ram_wr.en          = 1'b1;
          ram_wr.addr        = idx_r;
          ram_wr.data.stamp  = req_r.time_stamp;
          ram_wr.data.handle = req_r.payload_handle;
          valid_nxt[idx_r]   = 1'b1;
          count_nxt          = CNT_W'(count_r + 1'b1);
          res_nxt.status       = ST_STORED;
          res_nxt.out_stamp    = '0;
          res_nxt.out_handle   = '0;
          res_nxt.live_entries = live_of(CNT_W'(count_r + 1'b1));
          state_nxt            = S_DONE;
        end else if (idx_r == last_idx) begin
          res_nxt.status       = ST_FULL;
          res_nxt.out_stamp    = '0;
          res_nxt.out_handle   = '0;
          res_nxt.live_entries = live_of(count_r);
          state_nxt            = S_DONE;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end
      S_GET: begin
        // read slot idx_r now, compare it next cycle
        ram_rd.en   = 1'b1;
        ram_rd.addr = idx_r;
        rd_pend_nxt = 1'b1;
        rd_hit_nxt  = valid_r[idx_r];
        rd_idx_nxt  = idx_r;
        if (idx_r == last_idx) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = IDX_W'(idx_r + 1'b1);
        end
      end
      S_DRAIN: begin
        rd_pend_nxt = 1'b0;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (found_r) begin
          valid_nxt[best_idx_r] = 1'b0;
          if (count_r != '0) begin
            count_nxt = CNT_W'(count_r - 1'b1);
          end
          res_nxt.status     = ST_RETURNED;
          res_nxt.out_stamp  = best_r.stamp;
          res_nxt.out_handle = best_r.handle;
          res_nxt.live_entries =
            live_of((count_r != '0) ? CNT_W'(count_r - 1'b1) : count_r);
        end else begin
          res_nxt.status       = ST_EMPTY;
          res_nxt.out_stamp    = '0;
          res_nxt.out_handle   = '0;
          res_nxt.live_entries = live_of(count_r);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    rd_hit_r   <= rd_hit_nxt;
    rd_idx_r   <= rd_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
      found_r   <= found_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res_item  = res_r;

endmodule

`default_nettype wire

// ----- hdl/min_timestamp_slot_pool_top.sv -----
// top level of the min timestamp slot pool: configuration register, output
// register, slot memory and sequencer; depends on mtsp_pkg, mtsp_slot_ram, mtsp_seq
`default_nettype none

// Pool of timestamped slots. A put stores its timestamp and handle in the lowest
// free slot among the active ones (status full when none is free); a get
// removes the valid active entry with the smallest timestamp, the highest slot on
// ties, or reports empty. Every request gives one result with the live count.
// One request is worked at a time by a slot-by-slot scan over the active slots,
// whose count is 10 when the register holds 0 and is capped at the pool depth;
// a get does one slot memory read and one 64-bit compare per slot. The next
// request is taken as soon as the result moves into the output register, even
// while that result is still stalled. cfg_wdata sets the active slot count.
module min_timestamp_slot_pool_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  mtsp_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output mtsp_pkg::out_item_t  out_item,
  input  wire                  cfg_we,
  input  mtsp_pkg::act_t       cfg_wdata
);
  import mtsp_pkg::*;

  act_t       active_r;
  act_t       act_eff;
  act_t       used;
  idx_t       last_idx;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       seq_in_ready;
  logic       seq_res_valid;
  logic       seq_res_ready;
  out_item_t  seq_res_item;
  ram_wr_t    ram_wr;
  ram_rd_t    ram_rd;
  slot_t      rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  // zero selects the default slot count, anything past the depth saturates
  always_comb begin
    act_eff  = (active_r == '0) ? DEFAULT_ACTIVE : active_r;
    used     = (int'(act_eff) > POOL_DEPTH) ? ACT_W'(POOL_DEPTH) : act_eff;
    last_idx = IDX_W'(used - 1'b1);
  end

  assign seq_res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (seq_res_valid && seq_res_ready) begin
      out_item_r <= seq_res_item;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_res_ready) begin
      out_valid_r <= seq_res_valid;
    end
  end

  mtsp_slot_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd      (ram_rd),
    .rd_data (rd_data)
  );

  mtsp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (seq_in_ready),
    .in_item   (in_item),
    .last_idx  (last_idx),
    .res_valid (seq_res_valid),
    .res_ready (seq_res_ready),
    .res_item  (seq_res_item),
    .ram_wr    (ram_wr),
    .ram_rd    (ram_rd),
    .rd_data   (rd_data)
  );

  assign in_stall  = !seq_in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("pool took a request without going busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_res_valid && seq_res_ready) |=> out_valid_r)
    else $error("finished result not moved to the output register");

  a_put_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.status == ST_STORED || out_item_r.status == ST_FULL ||
                     out_item_r.status == ST_EMPTY))
    |-> (out_item_r.out_stamp == '0 && out_item_r.out_handle == '0))
    else $error("stamp or handle nonzero on a result without an entry");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (POOL_DEPTH > 31 || int'(out_item_r.live_entries) <= POOL_DEPTH))
    else $error("live count above pool depth");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for min_timestamp_slot_pool_top: directed and random
// put/get transfers against a slot pool predictor; depends on mtsp_pkg and the RTL
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtsp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 80;

  // predicts each result from the requests accepted so far
  class slot_pool_scoreboard;
    stamp_t      stamp_mem [POOL_DEPTH];
    pld_handle_t handle_mem[POOL_DEPTH];
    bit          valid_mem [POOL_DEPTH];
    int unsigned live_count = 0;
    act_t        active_reg = ACTIVE_RESET;
    out_item_t   expected_results[$];
    int          errors = 0;

    function void write_active(act_t value);
      active_reg = value;
    endfunction

    function int unsigned slots_in_use();
      int unsigned n;
      n = (active_reg == 0) ? int'(DEFAULT_ACTIVE) : int'(active_reg);
      if (n > POOL_DEPTH) n = POOL_DEPTH;
      return n;
    endfunction

    function void note_request(in_item_t req);
      out_item_t   res;
      int unsigned n;
      bit          found;
      int unsigned best;
      n = slots_in_use();
      found = 0;
      best = 0;
      res = '0;
      if (req.req_type == REQ_PUT) begin
        res.status = ST_FULL;
        for (int unsigned i = 0; i < n; i++) begin
          if (!valid_mem[i]) begin
            stamp_mem[i]  = req.time_stamp;
            handle_mem[i] = req.payload_handle;
            valid_mem[i]  = 1'b1;
            live_count++;
            res.status = ST_STORED;
            break;
          end
        end
      end else begin
        // <= so that the highest slot wins a tie
        for (int unsigned i = 0; i < n; i++) begin
          if (valid_mem[i] && (!found || stamp_mem[i] <= stamp_mem[best])) begin
            found = 1'b1;
            best  = i;
          end
        end
        if (found) begin
          res.status     = ST_RETURNED;
          res.out_stamp  = stamp_mem[best];
          res.out_handle = handle_mem[best];
          valid_mem[best] = 1'b0;
          if (live_count > 0) live_count--;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      res.live_entries = live_t'(live_count);
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
      if (exp_val !== got_val) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        compare_field("status", 64'(exp_res.status), 64'(got.status));
        compare_field("out_stamp", exp_res.out_stamp, got.out_stamp);
        compare_field("out_handle", 64'(exp_res.out_handle), 64'(got.out_handle));
        compare_field("live_entries", 64'(exp_res.live_entries), 64'(got.live_entries));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  act_t      cfg_wdata;

  slot_pool_scoreboard sb;
  bit          idling;
  int          stall_run = 0;
  int unsigned cycle_count = 0;

  min_timestamp_slot_pool_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side stalls in bursts
  always @(posedge clk) begin
    if (stall_run == 0 && idling && $urandom_range(0, 5) == 0)
      stall_run = $urandom_range(1, 12);
    if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  task automatic send_request(input logic kind, input stamp_t stamp, input pld_handle_t handle);
    in_item_t req;
    req.req_type       = kind;
    req.time_stamp     = stamp;
    req.payload_handle = handle;
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // register writes only with nothing in flight
  task automatic write_active(input act_t value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_active(value);
  endtask

  function automatic stamp_t pick_stamp();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return stamp_t'($urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic pld_handle_t pick_handle();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    act_t        phase_active[NUM_PHASES];
    int unsigned put_pct;
    int unsigned run_len;
    int unsigned sent;
    logic        kind;

    phase_active = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd4,
                     5'd17, 5'd16, 5'd2, 5'd10, 5'd16};
    sb = new;
    idling      = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty pool, extreme fields, tie on stamp zero
    send_request(REQ_GET, '1, '1);
    send_request(REQ_PUT, '1, '1);
    send_request(REQ_PUT, '0, '0);
    send_request(REQ_PUT, '0, 32'h0000_00a5);
    send_request(REQ_GET, '0, '0);
    send_request(REQ_GET, '0, '0);
    // two slots: second put is dropped
    write_active(5'd2);
    send_request(REQ_PUT, 64'd7, 32'd1);
    send_request(REQ_PUT, 64'd8, 32'd2);
    // zero selects the default slot count
    write_active(5'd0);
    send_request(REQ_GET, '0, '0);
    // above the depth, tie on the largest stamp
    write_active(5'd31);
    send_request(REQ_PUT, '1, 32'd3);
    send_request(REQ_GET, '0, '0);
    // slot 1 left live above the active range
    write_active(5'd16);
    send_request(REQ_PUT, 64'd5, 32'd4);
    write_active(5'd1);
    send_request(REQ_GET, '0, '0);
    send_request(REQ_GET, '0, '0);
    send_request(REQ_PUT, 64'd9, '0);
    send_request(REQ_PUT, 64'd6, 32'd6);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_active(phase_active[p]);
      idling  = (p != NUM_PHASES - 1);
      put_pct = $urandom_range(30, 70);
      sent    = 0;
      // runs of one request kind drive the pool to full and to empty
      while (sent < PHASE_ITEMS) begin
        kind    = ($urandom_range(0, 99) < put_pct) ? REQ_PUT : REQ_GET;
        run_len = $urandom_range(1, 20);
        if (run_len > PHASE_ITEMS - sent) run_len = PHASE_ITEMS - sent;
        repeat (run_len) begin
          send_request(kind, pick_stamp(), pick_handle());
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mtsp_pkg.sv
hdl/mtsp_slot_ram.sv
hdl/mtsp_seq.sv
hdl/min_timestamp_slot_pool_top.sv
tb/testbench.sv
